/* rtl/core/sbus_frame_decoder_unit_defines.svh */
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit_defines.svh
// Assertion macros for the frame decoder; empty bodies in synthesis.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_DECODER_UNIT_DEFINES_SVH
`define SBUS_FRAME_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define SBFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen out of reset
`define SBFD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SBFD_ASSERT(label, clk, rst, prop, msg)
`define SBFD_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

/* rtl/core/sbfd_pkg.sv */
// ----------------------------------------------------------------------------
// sbfd_pkg
// Shared types and constants of the SBUS frame decoder.
// ----------------------------------------------------------------------------
package sbfd_pkg;

   localparam int CHAN_COUNT = 16;
   localparam int CHAN_WIDTH = 11;
   localparam int DATA_LEN   = 22;

   // frame position codes
   localparam logic [4:0] POS_HUNT       = 5'd0;
   localparam logic [4:0] POS_FIRST_DATA = 5'd1;
   localparam logic [4:0] POS_LAST_DATA  = 5'd22;
   localparam logic [4:0] POS_FLAGS      = 5'd23;
   localparam logic [4:0] POS_FOOTER     = 5'd24;

   // register indexes
   localparam logic CSR_HEADER = 1'b0;
   localparam logic CSR_FOOTER = 1'b1;

   localparam logic [7:0] HEADER_RESET = 8'h0F;
   localparam logic [7:0] FOOTER_RESET = 8'h00;

   localparam logic [3:0] CHAN_LAST = 4'd15;

   // 22 data bytes, LSB-first; channel k sits at bit 11k
   typedef logic [CHAN_COUNT-1:0][CHAN_WIDTH-1:0] frame_type;

   // front to queue
   typedef struct packed {
      logic      push;
      frame_type frame;
   } queue_wr_type;

   // queue to back and front
   typedef struct packed {
      logic      valid;
      logic      full;
      frame_type frame;
   } queue_rd_type;

endpackage

/* rtl/core/sbus_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit
// SBUS 16-channel decoder: bytes in, one 11-bit channel value per word out.
//
//   channel  ports                              word
//   req      req_valid / req_stall              one received byte
//   rsp      rsp_valid / rsp_stall              channel index, value, last flag
//   csr      csr_write_enable / csr_index       header (0) or footer (1) byte
//
// The parser takes one byte per cycle unless stalled; a good footer pushes the
// frame into a two-entry queue. The emitter sends 16 words per frame, one per
// cycle unless stalled. req_stall rises only on a footer byte while both queue
// entries are taken. Reset is synchronous; no clearing pass is needed.
// rsp_stall holds the output register; the parser keeps running behind it.
// ----------------------------------------------------------------------------
`include "sbus_frame_decoder_unit_defines.svh"

module sbus_frame_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_channel_index,
   output logic [10:0] rsp_channel_value,
   output logic        rsp_frame_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);
   import sbfd_pkg::*;

   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         queue_pop;

   // byte parser
   sbfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_rd.full),
      .queue_wr         (queue_wr)
   );

   // frame queue
   sbfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .queue_wr  (queue_wr),
      .queue_pop (queue_pop),
      .queue_rd  (queue_rd)
   );

   // channel emitter
   sbfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_rd          (queue_rd),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_frame_last    (rsp_frame_last)
   );

   // checks
   `SBFD_ASSERT(a_last_on_chan15, clock, reset, rsp_valid && rsp_frame_last |-> rsp_channel_index == CHAN_LAST, "frame_last on a channel other than 15")
   `SBFD_ASSERT(a_chan_sequence, clock, reset, rsp_valid && !rsp_stall && !rsp_frame_last |=> rsp_valid && rsp_channel_index == $past(rsp_channel_index) + 4'd1, "channel run broken inside a frame")
   `SBFD_ASSERT_NEVER(a_stall_needs_frame, clock, reset, req_stall && !queue_rd.valid, "input stalled with an empty frame queue")

endmodule

/* rtl/core/sbfd_front.sv */
// ----------------------------------------------------------------------------
// sbfd_front
// Byte parser: header hunt, data byte capture, footer check, frame push.
// ----------------------------------------------------------------------------
module sbfd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [7:0]            csr_write_data,
   input  logic                  queue_full,
   output sbfd_pkg::queue_wr_type queue_wr
);
   import sbfd_pkg::*;

   logic [7:0]  header_ff;
   logic [7:0]  footer_ff;
   logic [4:0]  pos_ff;
   logic [4:0]  pos_in;
   logic [7:0]  prior_ff;
   logic [DATA_LEN*8-1:0] data_ff;
   logic [DATA_LEN*8-1:0] data_in;
   logic        accept;
   logic        push;

   // hold the footer word only when no frame slot is free
   assign req_stall = (pos_ff == POS_FOOTER) && queue_full;
   assign accept    = req_valid && !req_stall;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         footer_ff <= FOOTER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HEADER: header_ff <= csr_write_data;
            CSR_FOOTER: footer_ff <= csr_write_data;
            default:    ;
         endcase
      end
   end

   // position / capture next state
   always_comb begin
      pos_in  = pos_ff;
      data_in = data_ff;
      push    = 1'b0;
      if (accept) begin
         if (pos_ff == POS_HUNT) begin
            if (req_rx_byte == header_ff && prior_ff == footer_ff) begin
               pos_in = POS_FIRST_DATA;
            end
         end else if (pos_ff <= POS_FLAGS) begin
            // data bytes shift in from the top; flags word is dropped
            if (pos_ff <= POS_LAST_DATA) begin
               data_in = {req_rx_byte, data_ff[DATA_LEN*8-1:8]};
            end
            pos_in = pos_ff + 5'd1;
         end else if (pos_ff == POS_FOOTER) begin
            push   = (req_rx_byte == footer_ff);
            pos_in = POS_HUNT;
         end else begin
            pos_in = POS_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HUNT;
         prior_ff <= FOOTER_RESET;
      end else begin
         pos_ff <= pos_in;
         if (accept) begin
            prior_ff <= req_rx_byte;
         end
      end
   end

   // data bytes need no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign queue_wr.push  = push;
   assign queue_wr.frame = frame_type'(data_ff);

endmodule

/* rtl/core/sbfd_queue.sv */
// ----------------------------------------------------------------------------
// sbfd_queue
// Two-frame queue between the byte parser and the channel emitter.
// ----------------------------------------------------------------------------
module sbfd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  sbfd_pkg::queue_wr_type queue_wr,
   input  logic                   queue_pop,
   output sbfd_pkg::queue_rd_type queue_rd
);
   import sbfd_pkg::*;

   frame_type  entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign do_push = queue_wr.push && (count_ff != 2'd2);
   assign do_pop  = queue_pop && (count_ff != 2'd0);

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // frame storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= queue_wr.frame;
      end
   end

   assign queue_rd.valid = (count_ff != 2'd0);
   assign queue_rd.full  = (count_ff == 2'd2);
   assign queue_rd.frame = entry_ff[rd_ptr_ff];

endmodule

/* rtl/core/sbfd_back.sv */
// ----------------------------------------------------------------------------
// sbfd_back
// Channel emitter: walks the head frame, one 11-bit channel per word.
// ----------------------------------------------------------------------------
module sbfd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  sbfd_pkg::queue_rd_type queue_rd,
   output logic                   queue_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_channel_index,
   output logic [10:0]            rsp_channel_value,
   output logic                   rsp_frame_last
);
   import sbfd_pkg::*;

   logic [3:0]  chan_ff;
   logic        out_valid_ff;
   logic [3:0]  out_index_ff;
   logic [10:0] out_value_ff;
   logic        out_last_ff;
   logic        load;
   logic        issue;

   // output register free or draining this cycle
   assign load      = !out_valid_ff || !rsp_stall;
   assign issue     = load && queue_rd.valid;
   assign queue_pop = issue && (chan_ff == CHAN_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= queue_rd.valid;
         end
         if (issue) begin
            chan_ff <= chan_ff + 4'd1;
         end
      end
   end

   // payload of the output register
   always_ff @(posedge clock) begin
      if (issue) begin
         out_index_ff <= chan_ff;
         out_value_ff <= queue_rd.frame[chan_ff];
         out_last_ff  <= (chan_ff == CHAN_LAST);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_index = out_index_ff;
   assign rsp_channel_value = out_value_ff;
   assign rsp_frame_last    = out_last_ff;

endmodule

/* tb/sbus_frame_decoder_unit_test.sv */
// ----------------------------------------------------------------------------
// sbus_frame_decoder_unit_test
// Drives received bytes into the SBUS frame decoder and checks every channel
// word against a frame parser kept in step inside the bench. The run covers
// clean frames, bad footers, cut-short frames and line noise, under several
// header/footer settings. It also covers a long output hold-off that backs
// up the frame queue.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_unit_test;
   import sbfd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_WAIT  = 8;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int HOLDOFF_LEN  = 300;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_type;

   typedef struct {
      logic [3:0]            index;
      logic [CHAN_WIDTH-1:0] value;
      logic                  last;
   } channel_word_type;

   // DUT ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_channel_index;
   logic [10:0] rsp_channel_value;
   logic        rsp_frame_last;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_HEADER;
   logic [7:0]  csr_write_data = 8'h00;

   // parser copy kept by the bench
   logic [7:0] cfg_header = HEADER_RESET;
   logic [7:0] cfg_footer = FOOTER_RESET;
   logic [4:0] parse_pos  = POS_HUNT;
   logic [7:0] last_byte  = FOOTER_RESET;
   logic [7:0] frame_data [DATA_LEN];

   channel_word_type channel_words_due[$];

   // traffic shaping
   bit             gaps_on = 1'b1;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_RANDOM;
   int             hold_left = 0;
   int             stall_run = 0;
   bit             stall_level = 1'b0;

   int cycle_count = 0;
   int error_count = 0;

   sbus_frame_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_frame_last    (rsp_frame_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // advance the parser by one accepted byte; a good footer queues 16 words
   task automatic decode_rx_byte(input logic [7:0] b);
      logic [CHAN_COUNT*CHAN_WIDTH-1:0] bits;
      channel_word_type w;
      int j;
      int k;
      if (parse_pos == POS_HUNT) begin
         if (b == cfg_header && last_byte == cfg_footer)
            parse_pos = POS_FIRST_DATA;
      end else if (parse_pos <= POS_FLAGS) begin
         // the flags byte is swallowed without being stored
         if (parse_pos <= POS_LAST_DATA)
            frame_data[parse_pos - POS_FIRST_DATA] = b;
         parse_pos = parse_pos + 5'd1;
      end else if (parse_pos == POS_FOOTER) begin
         if (b == cfg_footer) begin
            for (j = 0; j < DATA_LEN; j++)
               bits[j*8 +: 8] = frame_data[j];
            for (k = 0; k < CHAN_COUNT; k++) begin
               w.index = 4'(k);
               w.value = bits[k*CHAN_WIDTH +: CHAN_WIDTH];
               w.last  = (4'(k) == CHAN_LAST);
               channel_words_due.push_back(w);
            end
         end
         parse_pos = POS_HUNT;
      end else begin
         parse_pos = POS_HUNT;
      end
      last_byte = b;
   endtask

   // offer one byte and hold it until taken; bursts with random gaps
   task automatic send_byte(input logic [7:0] b);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_rx_byte(b);
      if (burst_left > 0) burst_left--;
   endtask

   // both registers, back to back, enable held high across the pair
   task automatic write_config(input logic [7:0] hdr, input logic [7:0] ftr);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HEADER;
      csr_write_data   <= hdr;
      @(posedge clock);
      cfg_header = hdr;
      csr_index      <= CSR_FOOTER;
      csr_write_data <= ftr;
      @(posedge clock);
      cfg_footer = ftr;
      csr_write_enable <= 1'b0;
   endtask

   // close any open frame with non-header filler, then wait for the output
   task automatic settle_and_drain;
      while (parse_pos != POS_HUNT) send_byte(cfg_header ^ 8'h01);
      req_valid <= 1'b0;
      while (channel_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_data_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_frame(input bit good_footer);
      int j;
      if (last_byte != cfg_footer) send_byte(cfg_footer);
      send_byte(cfg_header);
      for (j = 0; j < DATA_LEN; j++) send_byte(pick_data_byte());
      send_byte(pick_data_byte());
      if (good_footer)
         send_byte(cfg_footer);
      else
         send_byte(cfg_footer ^ 8'($urandom_range(1, 255)));
   endtask

   // header followed by a partial payload; later bytes land mid-frame
   task automatic send_broken_frame;
      int j;
      int n;
      n = $urandom_range(1, DATA_LEN);
      if (last_byte != cfg_footer) send_byte(cfg_footer);
      send_byte(cfg_header);
      for (j = 0; j < n; j++) send_byte(pick_data_byte());
   endtask

   task automatic run_frames(input int count);
      int i;
      int j;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            for (j = $urandom_range(1, 4); j > 0; j--)
               send_byte(8'($urandom_range(0, 255)));
         end
         case ($urandom_range(0, 9))
            0: send_frame(1'b0);
            1: send_broken_frame();
            default: send_frame(1'b1);
         endcase
      end
   endtask

   // receiver stall: long hold-off first, else the selected pattern
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: begin
               if (stall_run == 0) begin
                  stall_level = !stall_level;
                  stall_run = stall_level ? $urandom_range(1, 6) : $urandom_range(1, 12);
               end
               stall_run--;
               rsp_stall <= stall_level;
            end
         endcase
      end
   end

   // output checker
   always @(posedge clock) begin
      channel_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (channel_words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word: channel %0d value %0d",
                                      rsp_channel_index, rsp_channel_value));
         end else begin
            want = channel_words_due.pop_front();
            if (rsp_channel_index !== want.index)
               report_mismatch($sformatf("channel_index got %0d expected %0d",
                                         rsp_channel_index, want.index));
            if (rsp_channel_value !== want.value)
               report_mismatch($sformatf("channel %0d value got %0d expected %0d",
                                         want.index, rsp_channel_value, want.value));
            if (rsp_frame_last !== want.last)
               report_mismatch($sformatf("channel %0d frame_last got %0b expected %0b",
                                         want.index, rsp_frame_last, want.last));
         end
      end
   end

   // footer moved before the first byte: a leading header must not open a frame
   task automatic test_footer_moved_after_reset;
      int j;
      write_config(HEADER_RESET, 8'hFF);
      send_byte(HEADER_RESET);
      send_byte(8'hFF);
      send_byte(HEADER_RESET);
      // all-ones then all-zeros data: channels 0-7 full scale, 8-15 zero
      for (j = 0; j < DATA_LEN; j++)
         send_byte((j < DATA_LEN / 2) ? 8'hFF : 8'h00);
      send_byte(8'hA5);
      send_byte(8'hFF);
      settle_and_drain();
   endtask

   task automatic test_default_registers;
      write_config(HEADER_RESET, FOOTER_RESET);
      send_frame(1'b0);
      run_frames(2);
      settle_and_drain();
   endtask

   task automatic test_extreme_registers;
      write_config(8'hFF, 8'h00);
      run_frames(1);
      settle_and_drain();
      stall_mode = STALL_BURSTY;
      write_config(8'h00, 8'hFF);
      run_frames(2);
      settle_and_drain();
   endtask

   task automatic test_header_equals_footer;
      stall_mode = STALL_RANDOM;
      write_config(8'h5A, 8'h5A);
      send_frame(1'b1);
      run_frames(1);
      settle_and_drain();
   endtask

   // hold the output off while frames stream in back to back
   task automatic test_output_backpressure;
      int i;
      write_config(HEADER_RESET, FOOTER_RESET);
      gaps_on    = 1'b0;
      stall_mode = STALL_NONE;
      hold_left  = HOLDOFF_LEN;
      for (i = 0; i < 4; i++) send_frame(1'b1);
      settle_and_drain();
      gaps_on    = 1'b1;
      stall_mode = STALL_BURSTY;
   endtask

   task automatic test_random_registers;
      logic [7:0] hdr;
      hdr = 8'($urandom_range(0, 255));
      write_config(hdr, hdr ^ 8'($urandom_range(1, 255)));
      run_frames(1);
      settle_and_drain();
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_footer_moved_after_reset();
      test_default_registers();
      test_extreme_registers();
      test_header_equals_footer();
      test_output_backpressure();
      test_random_registers();

      waited = 0;
      while (channel_words_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_WAIT * 2) @(posedge clock);
      if (channel_words_due.size() != 0)
         report_mismatch($sformatf("%0d channel words never arrived",
                                   channel_words_due.size()));
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
